[hdl/psched_pkg.sv]
// ----------------------------------------------------------------------------
// psched_pkg
// Shared types and constants of the tick-driven job scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TickUnitsDef  = 1;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned RemW   = 18;
  localparam int unsigned WaitW  = 32;

  localparam logic [1:0] ModeFcfs = 2'd0;
  localparam logic [1:0] ModeSjf  = 2'd1;
  localparam logic [1:0] ModeRr   = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  localparam logic       OpArrive = 1'b0;
  localparam logic       OpTick   = 1'b1;

  localparam logic       StFinish = 1'b0;
  localparam logic       StDrop   = 1'b1;

  localparam logic [1:0] CfgMode  = 2'd0;
  localparam logic [1:0] CfgSlice = 2'd1;
  localparam logic [1:0] CfgCost  = 2'd2;

  // One ready table entry.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    logic [RemW-1:0]   rem;
    logic [WaitW-1:0]  wait_t;
  } job_t;

  function automatic logic [WaitW-1:0] sat_inc(input logic [WaitW-1:0] a,
                                               input logic [WaitW-1:0] b);
    logic [WaitW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WaitW] ? '1 : s[WaitW-1:0];
  endfunction

endpackage

[hdl/psched_ram.sv]
// ----------------------------------------------------------------------------
// psched_ram
// Ready table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psched_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  psched_pkg::job_t     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output psched_pkg::job_t     rdata_o
);
  import psched_pkg::*;

  job_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/process_scheduler_fcfs_sjf_rr.sv]
// Timing: an arrival is taken in IDLE and arrivals can follow back to back; a dropped
// arrival's beat is valid in the cycle after it is taken. A tick holds the input stalled
// through the dispatch states (SCAN/SCANW over the table for shortest job first, then
// TAKE/TAKEW), the countdown (CNT), the sweep (SWEEP) and a round robin requeue (PUSH);
// a finished job's beat is valid in the cycle after CNT. A pending beat stalls the input.
// Reset: CPU idle, table empty (memory not cleared), registers at policy 0, slice 2, cost 0.
// ----------------------------------------------------------------------------
// process_scheduler_fcfs_sjf_rr
// FCFS / SJF / round robin job scheduler over a memory-held ready table.
// ----------------------------------------------------------------------------
module process_scheduler_fcfs_sjf_rr #(
  parameter int unsigned QueueDepth = psched_pkg::QueueDepthDef,
  parameter int unsigned TickUnits  = psched_pkg::TickUnitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  job_id_i,
  input  logic [15:0] burst_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [7:0]  done_id_o,
  output logic [15:0] done_burst_o,
  output logic [31:0] waited_ticks_o
);
  import psched_pkg::*;

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // issue read for SJF min search
  localparam logic [2:0] S_SCANW = 3'd2;  // compare that entry
  localparam logic [2:0] S_TAKE  = 3'd3;  // read chosen entry
  localparam logic [2:0] S_TAKEW = 3'd4;  // load it onto the CPU
  localparam logic [2:0] S_CNT   = 3'd5;  // count down the running job
  localparam logic [2:0] S_SWEEP = 3'd6;  // close the hole and age waiting jobs
  localparam logic [2:0] S_PUSH  = 3'd7;  // requeue the preempted job at the tail

  logic [2:0] state_q;
  logic [1:0] mode_q;
  logic [7:0] slice_q, cost_q;
  logic [CntW-1:0] cnt_q;
  logic run_v_q, any_fin_q;
  job_t run_q;
  logic [7:0] used_q;

  logic [CntW-1:0] idx_q;       // sweep read pointer
  logic [CntW-1:0] wi_q;        // sweep write pointer
  logic wv_q;                   // sweep write pending
  logic [CntW-1:0] best_q;
  logic [BurstW-1:0] best_b_q;
  logic take_q, push_q, charge_q;
  job_t pre_q;                  // preempted job waiting for the tail
  logic [CntW-1:0] hole_q;      // removed index (shift start)

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  job_t wdata, rdata;

  psched_ram #(.Depth(QueueDepth), .AddrW(AddrW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic out_v_q, st_q;
  logic [7:0] oid_q;
  logic [15:0] ob_q;
  logic [31:0] ow_q;
  assign out_valid_o    = out_v_q;
  assign status_o       = st_q;
  assign done_id_o      = oid_q;
  assign done_burst_o   = ob_q;
  assign waited_ticks_o = ow_q;

  logic acc, full;
  assign in_stall_o = (state_q != S_IDLE) || out_v_q;
  assign acc  = in_valid_i && !in_stall_o;
  assign full = (cnt_q >= CntW'(QueueDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeFcfs;
      slice_q <= 8'd2;
      cost_q  <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:  mode_q  <= cfg_data_i[1:0];
        CfgSlice: slice_q <= cfg_data_i;
        CfgCost:  cost_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Countdown with saturation; done when result <= 0.
  logic [RemW+9:0] amt_pos, rem_ext;
  logic signed [RemW+10:0] rnew;
  logic cd_done;
  logic [RemW-1:0] cd_rem;
  always_comb begin
    rem_ext = (RemW+10)'(run_q.rem);
    amt_pos = (RemW+10)'(TickUnits);
    rnew = charge_q ? $signed({1'b0, rem_ext}) - $signed({1'b0, amt_pos})
                        + $signed({1'b0, (RemW+10)'(cost_q)})
                    : $signed({1'b0, rem_ext}) - $signed({1'b0, amt_pos});
    cd_done = (rnew <= 0);
    if (rnew > $signed((RemW+11)'({RemW{1'b1}})))
      cd_rem = '1;
    else
      cd_rem = rnew[RemW-1:0];
  end

  logic [8:0] used_sum;
  logic [7:0] used_nxt;
  assign used_sum = {1'b0, used_q} + 9'(TickUnits);
  assign used_nxt = used_sum[8] ? 8'hFF : used_sum[7:0];

  // Dispatch decision of an active tick.
  logic go_take, go_push, go_charge, go_pre;
  always_comb begin
    go_take = 1'b0;
    go_push = 1'b0;
    go_charge = 1'b0;
    go_pre = (mode_q == ModeRr) && run_v_q && (used_q >= slice_q);
    if (mode_q == ModeRr) begin
      if (go_pre) begin
        go_take = (cnt_q != '0);
        go_push = (cnt_q != '0);
        go_charge = (cnt_q != '0);
      end else if (!run_v_q) begin
        go_take = 1'b1;
        go_charge = (cnt_q > CntW'(1)) && any_fin_q;
      end
    end else begin
      go_take = !run_v_q;
    end
  end

  job_t taken;
  always_comb begin
    taken = rdata;
    if (charge_q) taken.wait_t = sat_inc(rdata.wait_t, WaitW'(cost_q));
  end

  logic [CntW-1:0] src;
  assign src = idx_q + ((take_q && idx_q >= hole_q) ? CntW'(1) : CntW'(0));

  always_comb begin
    we = 1'b0;
    waddr = AddrW'(cnt_q);
    wdata = rdata;
    raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (acc && operation_i == OpArrive && !full) begin
          we = 1'b1;
          wdata.id = job_id_i;
          wdata.burst = burst_length_i;
          wdata.rem = RemW'(burst_length_i);
          wdata.wait_t = '0;
        end
      end
      S_SCAN: raddr = AddrW'(idx_q);
      S_TAKE: raddr = AddrW'(hole_q);
      S_SWEEP: begin
        if (idx_q < cnt_q) raddr = AddrW'(src);
        // entry wi is shifted down past the hole or kept in place, and aged either way
        if (wv_q) begin
          we = 1'b1;
          waddr = AddrW'(wi_q);
          wdata.wait_t = sat_inc(rdata.wait_t, WaitW'(TickUnits));
        end
      end
      S_PUSH: begin
        we = 1'b1;
        wdata = pre_q;
        wdata.wait_t = sat_inc(pre_q.wait_t, WaitW'(TickUnits));
      end
      default: ;
    endcase
  end

  logic res_set, res_st;
  logic [7:0] res_id;
  logic [15:0] res_b;
  logic [31:0] res_w;
  always_comb begin
    res_set = 1'b0;
    res_st = StFinish;
    res_id = run_q.id;
    res_b = run_q.burst;
    res_w = run_q.wait_t;
    if (state_q == S_IDLE && acc && operation_i == OpArrive && full) begin
      res_set = 1'b1;
      res_st = StDrop;
      res_id = job_id_i;
      res_b = burst_length_i;
      res_w = '0;
    end else if (state_q == S_CNT && cd_done) begin
      res_set = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      st_q <= StFinish;
      oid_q <= '0;
      ob_q <= '0;
      ow_q <= '0;
    end else if (res_set) begin
      out_v_q <= 1'b1;
      st_q <= res_st;
      oid_q <= res_id;
      ob_q <= res_b;
      ow_q <= res_w;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      run_v_q <= 1'b0;
      any_fin_q <= 1'b0;
      run_q <= '0;
      used_q <= '0;
      idx_q <= '0;
      wi_q <= '0;
      wv_q <= 1'b0;
      best_q <= '0;
      best_b_q <= '0;
      take_q <= 1'b0;
      push_q <= 1'b0;
      charge_q <= 1'b0;
      pre_q <= '0;
      hole_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (operation_i == OpArrive) begin
              if (!full) cnt_q <= cnt_q + CntW'(1);
            end else if (mode_q != ModeNone && (run_v_q || cnt_q != '0)) begin
              take_q <= go_take;
              push_q <= go_push;
              charge_q <= go_charge;
              pre_q <= run_q;
              idx_q <= '0;
              best_q <= '0;
              best_b_q <= '1;
              hole_q <= go_take ? '0 : CntW'(QueueDepth);
              if (go_pre) used_q <= '0;
              if (!go_take) state_q <= S_CNT;
              else state_q <= (mode_q == ModeSjf) ? S_SCAN : S_TAKE;
            end
          end
        end
        S_SCAN: begin
          state_q <= S_SCANW;
        end
        S_SCANW: begin
          if (rdata.burst < best_b_q) begin
            best_b_q <= rdata.burst; best_q <= idx_q;
          end
          if (idx_q + CntW'(1) >= cnt_q) begin
            state_q <= S_TAKE;
            hole_q <= (rdata.burst < best_b_q) ? idx_q : best_q;
          end else begin
            idx_q <= idx_q + CntW'(1); state_q <= S_SCAN;
          end
        end
        S_TAKE: begin
          state_q <= S_TAKEW;
        end
        S_TAKEW: begin
          run_q <= taken;
          run_v_q <= 1'b1;
          cnt_q <= cnt_q - CntW'(1);
          state_q <= S_CNT;
        end
        S_CNT: begin
          if (cd_done) begin
            run_v_q <= 1'b0;
            run_q <= '0;
            used_q <= '0;
            any_fin_q <= 1'b1;
          end else begin
            run_q.rem <= cd_rem;
            if (mode_q == ModeRr) used_q <= used_nxt;
          end
          idx_q <= '0;
          wv_q <= 1'b0;
          state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          if (idx_q < cnt_q) begin
            wi_q <= idx_q;
            wv_q <= 1'b1;
            idx_q <= idx_q + CntW'(1);
          end else begin
            wv_q <= 1'b0;
            state_q <= push_q ? S_PUSH : S_IDLE;
          end
        end
        S_PUSH: begin
          cnt_q <= cnt_q + CntW'(1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
